>>> rtl/operand_stack_engine_defines.svh
// ----------------------------------------------------------------------------
// Operand stack engine assertion macros
// Shared concurrent check forms, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef OPERAND_STACK_ENGINE_DEFINES_SVH
`define OPERAND_STACK_ENGINE_DEFINES_SVH

// Same-cycle implication: cons holds whenever ante holds.
`define OSE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons holds in the cycle after ante holds.
`define OSE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ose_pkg.sv
// ----------------------------------------------------------------------------
// Operand stack engine package
// Field widths, operation and status codes, and the shared plan and result types.
// ----------------------------------------------------------------------------
package ose_pkg;

  localparam int DEPTH_DEF  = 256;
  localparam int FUNC_W     = 4;
  localparam int DATA_W     = 32;
  localparam int OFF_W      = 8;
  localparam int WORD_W     = 16;
  localparam int STAT_W     = 2;
  localparam int CAP_W      = 9;
  localparam int PAIR_WORDS = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  localparam logic [FUNC_W-1:0] FN_PUSH         = 4'd0;
  localparam logic [FUNC_W-1:0] FN_POP          = 4'd1;
  localparam logic [FUNC_W-1:0] FN_PEEK         = 4'd2;
  localparam logic [FUNC_W-1:0] FN_PEEK_AT      = 4'd3;
  localparam logic [FUNC_W-1:0] FN_DUP          = 4'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR        = 4'd5;
  localparam logic [FUNC_W-1:0] FN_PUSH_PAIR    = 4'd6;
  localparam logic [FUNC_W-1:0] FN_POP_PAIR     = 4'd7;
  localparam logic [FUNC_W-1:0] FN_PEEK_PAIR    = 4'd8;
  localparam logic [FUNC_W-1:0] FN_PEEK_PAIR_AT = 4'd9;
  localparam logic [FUNC_W-1:0] FN_STATUS       = 4'd10;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVER  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_UNDER = 2'd2;

  // Memory sequence a request needs after it is taken.
  typedef enum logic [2:0] {
    SEQ_NONE,
    SEQ_READ,
    SEQ_READ_PAIR,
    SEQ_DUP,
    SEQ_WRITE_PAIR
  } seq_e;

  typedef struct packed {
    seq_e              seq;
    logic [STAT_W-1:0] status;
    logic              wr_en;
    logic              wr_hi;
    logic              empty;
    logic              full;
  } plan_t;

  // Packed so that data lies in the lowest bits, as on the output stream.
  typedef struct packed {
    logic              full;
    logic              empty;
    logic [CAP_W-1:0]  high_water;
    logic [CAP_W-1:0]  depth;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] data;
  } result_t;

endpackage

>>> rtl/ose_decode.sv
// ----------------------------------------------------------------------------
// Operand stack engine request decoder
// Checks a request against pointer and capacity, and plans addresses and pointer.
// ----------------------------------------------------------------------------
module ose_decode #(
  parameter int DEPTH = ose_pkg::DEPTH_DEF,
  parameter int PW    = $clog2(DEPTH + 1),
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic [ose_pkg::FUNC_W-1:0] func_i,
  input  logic [ose_pkg::OFF_W-1:0]  offset_i,
  input  logic [ose_pkg::CAP_W-1:0]  capacity_i,
  input  logic [PW-1:0]              sp_i,
  output ose_pkg::plan_t             plan_o,
  output logic [AW-1:0]              addr0_o,
  output logic [AW-1:0]              addr1_o,
  output logic [PW-1:0]              sp_next_o
);
  import ose_pkg::*;

  // Wide enough for the pointer, a doubled offset plus two, and the capacity.
  localparam int EW = ((PW > CAP_W) ? PW : CAP_W) + 2;

  logic [EW-1:0] sp_e;
  logic [EW-1:0] off_e;
  logic [EW-1:0] cap_e;
  logic [EW-1:0] reach;
  logic [EW-1:0] sp_n;
  logic [EW-1:0] a0;
  logic [EW-1:0] a1;

  assign sp_e  = EW'(sp_i);
  assign off_e = EW'(offset_i);
  // Zero or anything above the built depth means the full depth.
  assign cap_e = ((capacity_i == '0) || (EW'(capacity_i) > EW'(DEPTH))) ?
                 EW'(DEPTH) : EW'(capacity_i);

  always_comb begin
    plan_o        = '{seq: SEQ_NONE, status: STAT_OK, wr_en: 1'b0, wr_hi: 1'b0,
                      empty: 1'b0, full: 1'b0};
    sp_n          = sp_e;
    a0            = sp_e;
    a1            = sp_e + EW'(1);
    reach         = '0;
    unique case (func_i)
      FN_PUSH: begin
        if (sp_e >= cap_e) begin
          plan_o.status = STAT_OVER;
        end else begin
          plan_o.wr_en = 1'b1;
          sp_n         = sp_e + EW'(1);
        end
      end
      FN_POP: begin
        if (sp_e == '0) begin
          plan_o.status = STAT_UNDER;
        end else begin
          plan_o.seq = SEQ_READ;
          a0         = sp_e - EW'(1);
          sp_n       = sp_e - EW'(1);
        end
      end
      FN_PEEK, FN_PEEK_AT: begin
        reach = (func_i == FN_PEEK_AT) ? off_e : '0;
        if (reach >= sp_e) begin
          plan_o.status = STAT_UNDER;
        end else begin
          plan_o.seq = SEQ_READ;
          a0         = sp_e - EW'(1) - reach;
        end
      end
      FN_DUP: begin
        if (sp_e == '0) begin
          plan_o.status = STAT_UNDER;
        end else if (sp_e >= cap_e) begin
          plan_o.status = STAT_OVER;
        end else begin
          plan_o.seq = SEQ_DUP;
          a0         = sp_e - EW'(1);
          a1         = sp_e;
          sp_n       = sp_e + EW'(1);
        end
      end
      FN_CLEAR: begin
        sp_n = '0;
      end
      FN_PUSH_PAIR: begin
        if (sp_e + EW'(PAIR_WORDS) > cap_e) begin
          plan_o.status = STAT_OVER;
        end else begin
          plan_o.seq   = SEQ_WRITE_PAIR;
          plan_o.wr_en = 1'b1;
          plan_o.wr_hi = 1'b1;
          sp_n         = sp_e + EW'(PAIR_WORDS);
        end
      end
      FN_POP_PAIR, FN_PEEK_PAIR, FN_PEEK_PAIR_AT: begin
        reach = (func_i == FN_PEEK_PAIR_AT) ? (off_e << 1) : '0;
        if (reach + EW'(PAIR_WORDS) > sp_e) begin
          plan_o.status = STAT_UNDER;
        end else begin
          plan_o.seq = SEQ_READ_PAIR;
          a0         = sp_e - EW'(PAIR_WORDS) - reach;
          a1         = sp_e - EW'(1) - reach;
          if (func_i == FN_POP_PAIR) begin
            sp_n = sp_e - EW'(PAIR_WORDS);
          end
        end
      end
      default: begin
        // status and unused codes: report only
      end
    endcase
    plan_o.empty = (sp_n == '0);
    plan_o.full  = (sp_n >= cap_e);
  end

  assign addr0_o   = AW'(a0);
  assign addr1_o   = AW'(a1);
  assign sp_next_o = PW'(sp_n);

endmodule

>>> rtl/operand_stack_engine.sv
// ----------------------------------------------------------------------------
// Operand stack engine
// Bounded LIFO stack of 16-bit words with pair access and a high-water mark.
// ----------------------------------------------------------------------------
// One request per operation code, one result per request, in order. The words
// sit in a single synchronous RAM with one read and one write port and a
// registered read; the stack pointer and high-water mark are updated when a
// request is taken. Push, clear, status and failing requests finish when
// taken; pop, peek, peek at offset and dup read a word (dup then writes its
// copy), push pair writes the high then the low word, and pair reads fetch
// the high then the low word, in turn on the single RAM port pair. No request
// is taken before the last is through; a finished result waits in an output
// register, so a new request is taken while the previous result is still
// unclaimed, and a second result is held until the first leaves. Capacity is
// written through cfg_we_i / cfg_wdata_i; the user must write it only while
// the engine is idle; the block does not check it. Zero or a value above DEPTH
// selects DEPTH. Depth and high-water mark are reported in 9 bits. The RAM
// needs no clearing after reset: only entries below the pointer are ever read.
// ----------------------------------------------------------------------------
`include "operand_stack_engine_defines.svh"

module operand_stack_engine #(
  parameter int DEPTH = ose_pkg::DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // capacity register
  input  logic                           cfg_we_i,
  input  logic [ose_pkg::CAP_W-1:0]      cfg_wdata_i,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: func[3:0], data_in[35:4], offset[43:36], zero[47:44]
  input  logic [ose_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: data_out[31:0], status[33:32], depth[42:34], high_water_out[51:43],
  //        empty_res[52], full_res[53], zero[55:54]
  output logic [ose_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
  import ose_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);   // pointer, holds DEPTH itself
  localparam int AW = $clog2(DEPTH);       // word address

  localparam logic [2:0] S_IDLE  = 3'd0;   // ready for a request
  localparam logic [2:0] S_RDW   = 3'd1;   // word read data arriving
  localparam logic [2:0] S_RDH   = 3'd2;   // high word arriving, low read issued
  localparam logic [2:0] S_RDL   = 3'd3;   // low word arriving
  localparam logic [2:0] S_DUPW  = 3'd4;   // write duplicated word
  localparam logic [2:0] S_PAIRW = 3'd5;   // write low word of a pair
  localparam logic [2:0] S_HOLD  = 3'd6;   // result waits behind the output

  // Request fields
  logic [FUNC_W-1:0] func;
  logic [DATA_W-1:0] data_in;
  logic [OFF_W-1:0]  offset;

  assign func    = s_axis_tdata[FUNC_W-1:0];
  assign data_in = s_axis_tdata[FUNC_W +: DATA_W];
  assign offset  = s_axis_tdata[FUNC_W+DATA_W +: OFF_W];

  // Control state
  logic [2:0]       state_q, state_d;
  logic [PW-1:0]    sp_q, sp_d;
  logic [PW-1:0]    hw_q, hw_d;
  logic [CAP_W-1:0] cap_q;
  logic             out_valid_q, out_valid_d;

  // Payload
  result_t           out_q, out_d;
  result_t           hold_q;
  result_t           pend_q;
  logic [AW-1:0]     a1_q;
  logic [WORD_W-1:0] lo_q;
  logic [WORD_W-1:0] hi_q;

  // Word store
  logic [WORD_W-1:0] word_store_q [DEPTH];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Decode
  plan_t         plan;
  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic [PW-1:0] sp_next;
  logic [PW-1:0] hw_next;
  logic          accept;
  result_t       res_new;

  // Finish path
  logic    fin;
  result_t fin_res;
  logic    out_free;

  ose_decode #(
    .DEPTH (DEPTH),
    .PW    (PW),
    .AW    (AW)
  ) u_decode (
    .func_i     (func),
    .offset_i   (offset),
    .capacity_i (cap_q),
    .sp_i       (sp_q),
    .plan_o     (plan),
    .addr0_o    (addr0),
    .addr1_o    (addr1),
    .sp_next_o  (sp_next)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign hw_next       = (sp_next > hw_q) ? sp_next : hw_q;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Result fields known at acceptance; read data is filled in later.
  always_comb begin
    res_new            = '0;
    res_new.status     = plan.status;
    res_new.depth      = CAP_W'(sp_next);
    res_new.high_water = CAP_W'(hw_next);
    res_new.empty      = plan.empty;
    res_new.full       = plan.full;
  end

  // RAM port steering: first access at acceptance, second from the sequencer.
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = addr0;
    mem_we    = 1'b0;
    mem_waddr = addr0;
    mem_wdata = plan.wr_hi ? data_in[DATA_W-1 -: WORD_W] : data_in[WORD_W-1:0];
    if (accept) begin
      mem_re = (plan.seq == SEQ_READ) || (plan.seq == SEQ_READ_PAIR) ||
               (plan.seq == SEQ_DUP);
      mem_we = plan.wr_en;
    end else if (state_q == S_RDH) begin
      mem_re    = 1'b1;
      mem_raddr = a1_q;
    end else if (state_q == S_DUPW) begin
      mem_we    = 1'b1;
      mem_waddr = a1_q;
      mem_wdata = rdata_q;
    end else if (state_q == S_PAIRW) begin
      mem_we    = 1'b1;
      mem_waddr = a1_q;
      mem_wdata = lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      word_store_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= word_store_q[mem_raddr];
    end
  end

  // Sequencer: advance through the accesses, then hand the result on.
  always_comb begin
    state_d = state_q;
    fin     = 1'b0;
    fin_res = pend_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (plan.seq)
            SEQ_READ:       state_d = S_RDW;
            SEQ_READ_PAIR:  state_d = S_RDH;
            SEQ_DUP:        state_d = S_DUPW;
            SEQ_WRITE_PAIR: state_d = S_PAIRW;
            default: begin
              fin     = 1'b1;
              fin_res = res_new;
            end
          endcase
        end
      end
      S_RDW: begin
        fin          = 1'b1;
        fin_res.data = DATA_W'(rdata_q);
      end
      S_RDH: begin
        state_d = S_RDL;
      end
      S_RDL: begin
        fin          = 1'b1;
        fin_res.data = {hi_q, rdata_q};
      end
      S_DUPW: begin
        fin          = 1'b1;
        fin_res.data = DATA_W'(rdata_q);
      end
      S_PAIRW: begin
        fin = 1'b1;
      end
      S_HOLD: begin
        if (m_axis_tready) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // Park the result when the output register is still occupied.
    if (fin) begin
      state_d = out_free ? ((state_q == S_IDLE) ? state_d : S_IDLE) : S_HOLD;
    end
  end

  // Output register: load a finished or parked result, drop a taken one.
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (fin && out_free) begin
      out_valid_d = 1'b1;
      out_d       = fin_res;
    end else if ((state_q == S_HOLD) && m_axis_tready) begin
      out_valid_d = 1'b1;
      out_d       = hold_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  assign sp_d = accept ? sp_next : sp_q;
  assign hw_d = accept ? hw_next : hw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      hw_q        <= '0;
      cap_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      hw_q        <= hw_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      pend_q <= res_new;
      a1_q   <= addr1;
      lo_q   <= data_in[WORD_W-1:0];
    end
    if (state_q == S_RDH) begin
      hi_q <= rdata_q;
    end
    if (fin && !out_free) begin
      hold_q <= fin_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'(out_q);

  // Checks
  `OSE_ASSERT_NOW(a_sp_bound, clk_i, rst_ni, 1'b1, sp_q <= PW'(DEPTH),
                  "stack pointer beyond built depth")
  `OSE_ASSERT_NOW(a_hw_covers_sp, clk_i, rst_ni, 1'b1, hw_q >= sp_q,
                  "high-water mark below stack pointer")
  `OSE_ASSERT_NEXT(a_fail_keeps_sp, clk_i, rst_ni,
                   accept && (plan.status != STAT_OK), $stable(sp_q),
                   "failing request moved the stack pointer")
  `OSE_ASSERT_NOW(a_hold_behind_out, clk_i, rst_ni, state_q == S_HOLD,
                  m_axis_tvalid, "parked result without an occupied output")

endmodule

>>> bench/operand_stack_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Operand stack engine testbench
// Drives request streams into the stack engine, keeps an in-bench copy of the
// stack, pointer, high-water mark and capacity, and checks every result field
// in order against the copy. Covers directed corner cases, capacity limits,
// a fill to the full built depth, random traffic and a long output stall.
// ----------------------------------------------------------------------------
module operand_stack_engine_tb;
  import ose_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CAP_W-1:0]       cfg_wdata_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // tdata: func[3:0], data_in[35:4], offset[43:36], zero[47:44]
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // tdata: data_out[31:0], status[33:32], depth[42:34], high_water_out[51:43],
  //        empty_res[52], full_res[53], zero[55:54]
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  // Bench copy of the engine state.
  logic [WORD_W-1:0] stack_words [DEPTH_DEF];
  int unsigned       depth_now = 0;
  int unsigned       peak_depth = 0;
  logic [CAP_W-1:0]  cap_reg = '0;

  // Results still owed by the engine, oldest first.
  result_t     pending_results [$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  // Pacing controls shared by the sender, the sink and the tests.
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  int unsigned sink_hold_req = 0;

  // Random walk of the stack depth during random traffic.
  bit          climbing = 1'b1;
  int unsigned climb_target = 1;

  operand_stack_engine dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Usable words: zero or anything above the built depth selects the full depth.
  function automatic int unsigned eff_limit();
    if (cap_reg == '0 || cap_reg > DEPTH_DEF) return DEPTH_DEF;
    return 32'(cap_reg);
  endfunction

  // Apply one request to the bench stack and queue the result it must give.
  // A failing request leaves the stack alone and reports zero data.
  function automatic void apply_stack_op(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] din,
                                         logic [OFF_W-1:0] off);
    result_t     r;
    int unsigned lim;
    int unsigned sp;
    int unsigned w;
    lim = eff_limit();
    sp  = depth_now;
    r   = '0;
    r.status = STAT_OK;
    case (fn)
      FN_PUSH: begin
        if (sp >= lim) begin
          r.status = STAT_OVER;
        end else begin
          stack_words[sp] = din[WORD_W-1:0];
          depth_now = sp + 1;
        end
      end
      FN_POP: begin
        if (sp == 0) begin
          r.status = STAT_UNDER;
        end else begin
          r.data = {16'h0000, stack_words[sp-1]};
          depth_now = sp - 1;
        end
      end
      FN_PEEK, FN_PEEK_AT: begin
        w = (fn == FN_PEEK) ? 0 : 32'(off);
        if (w >= sp) r.status = STAT_UNDER;
        else r.data = {16'h0000, stack_words[sp-1-w]};
      end
      FN_DUP: begin
        // Empty is checked first: an empty stack is an underflow, never an overflow.
        if (sp == 0) begin
          r.status = STAT_UNDER;
        end else if (sp >= lim) begin
          r.status = STAT_OVER;
        end else begin
          r.data = {16'h0000, stack_words[sp-1]};
          stack_words[sp] = stack_words[sp-1];
          depth_now = sp + 1;
        end
      end
      FN_CLEAR: depth_now = 0;
      FN_PUSH_PAIR: begin
        // High word goes in first so the low word ends up on top.
        if (sp + 2 > lim) begin
          r.status = STAT_OVER;
        end else begin
          stack_words[sp]   = din[31:16];
          stack_words[sp+1] = din[15:0];
          depth_now = sp + 2;
        end
      end
      FN_POP_PAIR, FN_PEEK_PAIR, FN_PEEK_PAIR_AT: begin
        w = (fn == FN_PEEK_PAIR_AT) ? 2 * 32'(off) : 0;
        if (w + 2 > sp) begin
          r.status = STAT_UNDER;
        end else begin
          r.data = {stack_words[sp-2-w], stack_words[sp-1-w]};
          if (fn == FN_POP_PAIR) depth_now = sp - 2;
        end
      end
      default: ;  // status and the unused codes change nothing
    endcase
    if (depth_now > peak_depth) peak_depth = depth_now;
    r.depth      = CAP_W'(depth_now);
    r.high_water = CAP_W'(peak_depth);
    r.empty      = (depth_now == 0);
    r.full       = (depth_now >= lim);
    pending_results.push_back(r);
  endfunction

  // Offer one request, hold it until taken, then predict its result.
  task automatic issue_request(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] din,
                               input logic [OFF_W-1:0] off);
    int unsigned gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, off, din, fn};
    do @(posedge clk_i); while (!s_axis_tready);
    apply_stack_op(fn, din, off);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  // Write capacity only once the engine has gone idle.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = value;
  endtask

  // Pick an operation, biased towards growing or shrinking the stack.
  function automatic logic [FUNC_W-1:0] pick_op(bit up);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < (up ? 40 : 15)) return FN_PUSH;
    if (roll < (up ? 58 : 22)) return FN_PUSH_PAIR;
    if (roll < (up ? 66 : 55)) return FN_POP;
    if (roll < (up ? 70 : 68)) return FN_POP_PAIR;
    if (roll < (up ? 76 : 75)) return FN_PEEK_AT;
    if (roll < (up ? 79 : 78)) return FN_PEEK;
    if (roll < (up ? 85 : 83)) return FN_DUP;
    if (roll < (up ? 90 : 89)) return FN_PEEK_PAIR_AT;
    if (roll < (up ? 93 : 92)) return FN_PEEK_PAIR;
    if (roll < 95) return FN_STATUS;
    if (roll < 96) return FN_CLEAR;
    return FN_STATUS + FUNC_W'($urandom_range(1, 5));
  endfunction

  // One random request: offsets mostly land inside the stack, data is random
  // with the odd all-zeros or all-ones word.
  task automatic random_request();
    logic [FUNC_W-1:0] fn;
    logic [DATA_W-1:0] din;
    logic [OFF_W-1:0]  off;
    int unsigned       roll;
    if (depth_now == 0 || $urandom_range(0, 199) == 0) begin
      climbing     = 1'b1;
      climb_target = $urandom_range(1, eff_limit());
    end else if (depth_now >= climb_target) begin
      climbing = 1'b0;
    end
    fn   = pick_op(climbing);
    roll = $urandom_range(0, 9);
    din  = (roll == 0) ? '0 : (roll == 1) ? '1 : DATA_W'($urandom);
    roll = $urandom_range(0, 99);
    if (fn == FN_PEEK_AT && roll < 75)
      off = OFF_W'($urandom_range(0, (depth_now > 255) ? 255 : depth_now));
    else if (fn == FN_PEEK_PAIR_AT && roll < 75)
      off = OFF_W'($urandom_range(0, depth_now / 2));
    else
      off = OFF_W'($urandom);
    issue_request(fn, din, off);
  endtask

  // Empty-stack failures, the word and pair paths, offsets at both ends,
  // the unused codes and clear.
  task automatic test_empty_and_basic_ops();
    issue_request(FN_STATUS,       $urandom, 8'h00);
    issue_request(FN_POP,          $urandom, 8'h00);
    issue_request(FN_PEEK,         $urandom, 8'hFF);
    issue_request(FN_PEEK_AT,      $urandom, 8'h00);
    issue_request(FN_DUP,          $urandom, 8'h00);
    issue_request(FN_POP_PAIR,     $urandom, 8'h00);
    issue_request(FN_PEEK_PAIR,    $urandom, 8'h00);
    issue_request(FN_PEEK_PAIR_AT, $urandom, 8'h00);
    issue_request(FN_PUSH,         32'hFFFF_FFFF, 8'hFF);
    issue_request(FN_PUSH,         32'h1234_0000, 8'h00);
    issue_request(FN_PEEK,         $urandom, 8'h00);
    issue_request(FN_PEEK_AT,      $urandom, 8'h01);
    issue_request(FN_PEEK_AT,      $urandom, 8'h02);
    issue_request(FN_PEEK_AT,      $urandom, 8'hFF);
    issue_request(FN_DUP,          $urandom, 8'h00);
    issue_request(FN_PUSH_PAIR,    32'hDEAD_BEEF, 8'h00);
    issue_request(FN_PEEK_PAIR,    $urandom, 8'h00);
    issue_request(FN_PEEK_PAIR_AT, $urandom, 8'h01);
    issue_request(FN_PEEK_PAIR_AT, $urandom, 8'hFF);
    issue_request(FN_POP_PAIR,     $urandom, 8'h00);
    issue_request(FN_POP,          $urandom, 8'h00);
    issue_request(FN_STATUS + 4'd1, $urandom, 8'h00);
    issue_request(FN_STATUS + 4'd5, $urandom, 8'hFF);
    issue_request(FN_CLEAR,        $urandom, 8'h00);
    issue_request(FN_STATUS,       $urandom, 8'h00);
  endtask

  // Small capacities, pair pushes that do not fit, capacity lowered below
  // the depth, and a capacity above the built depth.
  task automatic test_capacity_limits();
    write_capacity(9'd1);
    issue_request(FN_PUSH,      $urandom, 8'h00);
    issue_request(FN_PUSH,      $urandom, 8'h00);
    issue_request(FN_DUP,       $urandom, 8'h00);
    issue_request(FN_PUSH_PAIR, $urandom, 8'h00);
    issue_request(FN_POP,       $urandom, 8'h00);
    issue_request(FN_PUSH_PAIR, $urandom, 8'h00);
    write_capacity(9'd2);
    issue_request(FN_PUSH_PAIR, $urandom, 8'h00);
    issue_request(FN_PUSH,      $urandom, 8'h00);
    issue_request(FN_PEEK_PAIR, $urandom, 8'h00);
    issue_request(FN_POP_PAIR,  $urandom, 8'h00);
    write_capacity(9'd8);
    repeat (6) issue_request(FN_PUSH, $urandom, 8'h00);
    // Capacity now below depth: growth fails, reads and pops carry on.
    write_capacity(9'd3);
    issue_request(FN_PUSH,    $urandom, 8'h00);
    issue_request(FN_DUP,     $urandom, 8'h00);
    issue_request(FN_STATUS,  $urandom, 8'h00);
    repeat (4) issue_request(FN_POP, $urandom, 8'h00);
    issue_request(FN_PEEK_AT, $urandom, 8'h01);
    issue_request(FN_CLEAR,   $urandom, 8'h00);
    write_capacity(9'd257);
    issue_request(FN_STATUS,  $urandom, 8'h00);
  endtask

  // Fill to the full built depth, hit every overflow path there, read the
  // deepest word and pair, then empty the stack again.
  task automatic test_fill_to_depth();
    write_capacity('0);
    issue_request(FN_CLEAR, $urandom, 8'h00);
    while (depth_now < DEPTH_DEF) begin
      if (depth_now + 2 <= DEPTH_DEF && $urandom_range(0, 1) == 1)
        issue_request(FN_PUSH_PAIR, $urandom, 8'h00);
      else
        issue_request(FN_PUSH, $urandom, 8'h00);
    end
    issue_request(FN_PUSH,         $urandom, 8'h00);
    issue_request(FN_DUP,          $urandom, 8'h00);
    issue_request(FN_PUSH_PAIR,    $urandom, 8'h00);
    issue_request(FN_PEEK_AT,      $urandom, 8'hFF);
    issue_request(FN_PEEK_PAIR_AT, $urandom, 8'd127);
    issue_request(FN_PEEK_PAIR_AT, $urandom, 8'd128);
    write_capacity(9'd511);
    issue_request(FN_STATUS, $urandom, 8'h00);
    write_capacity(9'd256);
    issue_request(FN_PUSH,   $urandom, 8'h00);
    while (depth_now > 0) begin
      if (depth_now >= 2 && $urandom_range(0, 1) == 1)
        issue_request(FN_POP_PAIR, $urandom, 8'h00);
      else
        issue_request(FN_POP, $urandom, 8'h00);
    end
    issue_request(FN_POP,      $urandom, 8'h00);
    issue_request(FN_POP_PAIR, $urandom, 8'h00);
  endtask

  // Random traffic in phases, each with its own capacity and pacing.
  task automatic test_random_traffic(input int unsigned count);
    logic [CAP_W-1:0] cap_val;
    int unsigned      per_phase;
    per_phase = count / 8;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0:       cap_val = '0;
        1:       cap_val = 9'd1;
        2:       cap_val = 9'd2;
        3:       cap_val = CAP_W'($urandom_range(3, 40));
        4:       cap_val = 9'd255;
        5:       cap_val = 9'd511;
        6:       cap_val = CAP_W'($urandom_range(41, 256));
        default: cap_val = 9'd256;
      endcase
      write_capacity(cap_val);
      // Leave some phases without any idling on one side or the other.
      src_idle_on  = (phase % 3) != 1;
      sink_idle_on = (phase % 4) != 2;
      repeat (per_phase) random_request();
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Hold the sink off for a long stretch while requests keep coming, so the
  // engine fills its result registers and stalls its input.
  task automatic test_output_backpressure();
    src_idle_on   = 1'b0;
    sink_hold_req = 400;
    repeat (60) random_request();
    src_idle_on = 1'b1;
  endtask

  // Result sink pacing: random stalls, plus the long hold-off on request.
  always @(posedge clk_i) begin : sink_pacing
    int unsigned sink_wait;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait = 0;
    end else if (sink_hold_req != 0) begin
      sink_wait     = sink_hold_req;
      sink_hold_req = 0;
      m_axis_tready <= 1'b0;
    end else if (sink_wait != 0) begin
      sink_wait--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      sink_wait = sink_idle_on ? pick_gap() : 0;
    end
  end

  task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, seen);
      fail_count++;
    end
  endtask

  // Compare each result taken from the engine with the oldest prediction.
  always @(posedge clk_i) begin : result_check
    result_t seen;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual 0x%0h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("data_out",       want.data,               seen.data);
        check_field("status",         DATA_W'(want.status),     DATA_W'(seen.status));
        check_field("depth",          DATA_W'(want.depth),      DATA_W'(seen.depth));
        check_field("high_water_out", DATA_W'(want.high_water), DATA_W'(seen.high_water));
        check_field("empty_res",      DATA_W'(want.empty),      DATA_W'(seen.empty));
        check_field("full_res",       DATA_W'(want.full),       DATA_W'(seen.full));
      end
    end
  end

  // Hard stop for a hung run.
  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin : run_tests
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_and_basic_ops();
    test_capacity_limits();
    test_fill_to_depth();
    test_random_traffic(1150);
    test_output_backpressure();
    drain_results();
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
